FILE: hdl/ucb_pkg.sv
// ----------------------------------------------------------------------------
// ucb_pkg
// Shared types, codes and sizes of the serial command bridge.
// ----------------------------------------------------------------------------
package ucb_pkg;

  // Default width of the instruction slot counter
  localparam int INSTR_INDEX_BITS_DEFAULT = 16;

  // Entries in the job queue between front and back (power of two)
  localparam int JOB_QUEUE_DEPTH = 4;

  // Input item codes
  localparam logic [1:0] CMD_SERIAL_BYTE = 2'd0;
  localparam logic [1:0] CMD_READ_DATA   = 2'd1;
  localparam logic [1:0] CMD_KERNEL_DONE = 2'd2;

  // Serial command bytes
  localparam logic [7:0] OP_LOAD_INSTR  = 8'd1;
  localparam logic [7:0] OP_RESET_INDEX = 8'd2;
  localparam logic [7:0] OP_START       = 8'd3;
  localparam logic [7:0] OP_QUERY       = 8'd4;
  localparam logic [7:0] OP_READ_CYCLES = 8'd5;
  localparam logic [7:0] OP_LOAD_MEM    = 8'd6;
  localparam logic [7:0] OP_READ_MEM    = 8'd7;
  localparam logic [7:0] OP_WRITE_ZERO  = 8'd9;

  // Result kinds
  localparam logic [2:0] KIND_SEND_BYTE  = 3'd0;
  localparam logic [2:0] KIND_INSTR_WR   = 3'd1;
  localparam logic [2:0] KIND_MEM_WR     = 3'd2;
  localparam logic [2:0] KIND_MEM_RD     = 3'd3;
  localparam logic [2:0] KIND_CYCLES_RD  = 3'd4;
  localparam logic [2:0] KIND_START      = 3'd5;

  localparam logic [7:0]  DONE_BYTE      = 8'd50;
  localparam logic [31:0] WORD_STEP      = 32'd4;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  rx_byte;
    logic [31:0] read_data;
  } command_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  tx_byte;
    logic [15:0] instr_index;
    logic [31:0] bus_address;
    logic [31:0] bus_data;
    logic        last;
  } result_t;

  // One decoded request for the back end: an optional four-byte word to
  // send, then an optional closing result.
  typedef struct packed {
    logic        echo;
    logic [31:0] word;
    logic        has_tail;
    result_t     tail;
  } job_t;

endpackage

FILE: hdl/ucb_front.sv
// ----------------------------------------------------------------------------
// ucb_front
// Command decoder: takes input requests, tracks mode and pointers, emits jobs.
// ----------------------------------------------------------------------------
module ucb_front #(
  parameter int INSTR_INDEX_BITS = ucb_pkg::INSTR_INDEX_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  ucb_pkg::command_t command,
  input  logic              cfg_write,
  input  logic [31:0]       cfg_data,
  output logic              job_push,
  output ucb_pkg::job_t     job
);

  localparam logic [2:0] MODE_IDLE       = 3'd0;
  localparam logic [2:0] MODE_LOAD_INSTR = 3'd1;
  localparam logic [2:0] MODE_LOAD_MEM   = 3'd2;
  localparam logic [2:0] MODE_READ_ADDR  = 3'd3;
  localparam logic [2:0] MODE_RUNNING    = 3'd4;

  logic [2:0]                  mode, mode_next;
  logic [1:0]                  payload_count, payload_count_next;
  logic [23:0]                 payload_shift, payload_shift_next;
  logic [INSTR_INDEX_BITS-1:0] instr_counter, instr_counter_next;
  logic [31:0]                 memory_pointer, memory_pointer_next;
  logic                        read_pending, read_pending_next;
  logic [31:0]                 counter_wide;
  logic [31:0]                 word;
  logic                        in_payload;
  logic                        job_valid;

  assign counter_wide = 32'(instr_counter);
  assign word         = {payload_shift, command.rx_byte};
  assign in_payload   = (mode == MODE_LOAD_INSTR) || (mode == MODE_LOAD_MEM) ||
                        (mode == MODE_READ_ADDR);

  always_comb begin
    mode_next           = mode;
    payload_count_next  = payload_count;
    payload_shift_next  = payload_shift;
    instr_counter_next  = instr_counter;
    memory_pointer_next = memory_pointer;
    read_pending_next   = read_pending;
    job                 = '0;
    job_valid           = 1'b0;
    case (command.cmd)
      ucb_pkg::CMD_SERIAL_BYTE: begin
        if (in_payload) begin
          if (payload_count != 2'd3) begin
            payload_shift_next = {payload_shift[15:0], command.rx_byte};
            payload_count_next = payload_count + 2'd1;
          end else begin
            payload_count_next = '0;
            payload_shift_next = '0;
            mode_next          = MODE_IDLE;
            job_valid          = 1'b1;
            job.has_tail       = 1'b1;
            job.word           = word;
            if (mode == MODE_LOAD_INSTR) begin
              job.echo             = 1'b1;
              job.tail.kind        = ucb_pkg::KIND_INSTR_WR;
              job.tail.instr_index = counter_wide[15:0];
              job.tail.bus_data    = word;
              instr_counter_next   = instr_counter + INSTR_INDEX_BITS'(1);
            end else if (mode == MODE_LOAD_MEM) begin
              job.echo             = 1'b1;
              job.tail.kind        = ucb_pkg::KIND_MEM_WR;
              job.tail.bus_address = memory_pointer;
              job.tail.bus_data    = word;
              memory_pointer_next  = memory_pointer + ucb_pkg::WORD_STEP;
            end else begin
              job.tail.kind        = ucb_pkg::KIND_MEM_RD;
              job.tail.bus_address = word;
              read_pending_next    = 1'b1;
            end
          end
        end else begin
          case (command.rx_byte)
            ucb_pkg::OP_LOAD_INSTR: begin
              mode_next          = MODE_LOAD_INSTR;
              payload_count_next = '0;
              payload_shift_next = '0;
            end
            ucb_pkg::OP_RESET_INDEX: begin
              instr_counter_next = '0;
            end
            ucb_pkg::OP_START: begin
              job_valid     = 1'b1;
              job.has_tail  = 1'b1;
              job.tail.kind = ucb_pkg::KIND_START;
              mode_next     = MODE_RUNNING;
            end
            ucb_pkg::OP_QUERY: begin
              job_valid        = 1'b1;
              job.has_tail     = 1'b1;
              job.tail.kind    = ucb_pkg::KIND_SEND_BYTE;
              job.tail.tx_byte = {7'd0, mode == MODE_RUNNING};
            end
            ucb_pkg::OP_READ_CYCLES: begin
              job_valid         = 1'b1;
              job.has_tail      = 1'b1;
              job.tail.kind     = ucb_pkg::KIND_CYCLES_RD;
              read_pending_next = 1'b1;
            end
            ucb_pkg::OP_LOAD_MEM: begin
              mode_next          = MODE_LOAD_MEM;
              payload_count_next = '0;
              payload_shift_next = '0;
            end
            ucb_pkg::OP_READ_MEM: begin
              mode_next          = MODE_READ_ADDR;
              payload_count_next = '0;
              payload_shift_next = '0;
            end
            ucb_pkg::OP_WRITE_ZERO: begin
              job_valid            = 1'b1;
              job.has_tail         = 1'b1;
              job.tail.kind        = ucb_pkg::KIND_MEM_WR;
              job.tail.bus_address = memory_pointer;
              memory_pointer_next  = memory_pointer + ucb_pkg::WORD_STEP;
            end
            default: begin
            end
          endcase
        end
      end
      ucb_pkg::CMD_READ_DATA: begin
        if (read_pending) begin
          read_pending_next = 1'b0;
          job_valid         = 1'b1;
          job.echo          = 1'b1;
          job.word          = command.read_data;
        end
      end
      ucb_pkg::CMD_KERNEL_DONE: begin
        if (mode == MODE_RUNNING) begin
          mode_next        = MODE_IDLE;
          job_valid        = 1'b1;
          job.has_tail     = 1'b1;
          job.tail.kind    = ucb_pkg::KIND_SEND_BYTE;
          job.tail.tx_byte = ucb_pkg::DONE_BYTE;
        end
      end
      default: begin
      end
    endcase
  end

  assign job_push = accept && job_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_IDLE;
      payload_count  <= '0;
      payload_shift  <= '0;
      instr_counter  <= '0;
      memory_pointer <= '0;
      read_pending   <= 1'b0;
    end else if (cfg_write) begin
      memory_pointer <= cfg_data;
    end else if (accept) begin
      mode           <= mode_next;
      payload_count  <= payload_count_next;
      payload_shift  <= payload_shift_next;
      instr_counter  <= instr_counter_next;
      memory_pointer <= memory_pointer_next;
      read_pending   <= read_pending_next;
    end
  end

endmodule

FILE: hdl/ucb_job_fifo.sv
// ----------------------------------------------------------------------------
// ucb_job_fifo
// Short queue of decoded jobs between decoder and sequencer.
// ----------------------------------------------------------------------------
module ucb_job_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ucb_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output ucb_pkg::job_t head,
  output logic          empty
);

  localparam int DEPTH      = ucb_pkg::JOB_QUEUE_DEPTH;
  localparam int PTR_BITS   = $clog2(DEPTH);
  localparam int COUNT_BITS = $clog2(DEPTH + 1);

  ucb_pkg::job_t         entries [DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr, rd_ptr;
  logic [COUNT_BITS-1:0] count;

  assign full  = (count == COUNT_BITS'(DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + COUNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - COUNT_BITS'(1);
      end
    end
  end

endmodule

FILE: hdl/ucb_back.sv
// ----------------------------------------------------------------------------
// ucb_back
// Result sequencer: expands one job into its results, one per cycle while the result side pops.
// ----------------------------------------------------------------------------
module ucb_back (
  input  logic             clk,
  input  logic             rst,
  input  ucb_pkg::job_t    head,
  input  logic             job_empty,
  output logic             job_pop,
  output ucb_pkg::result_t result,
  output logic             empty,
  input  logic             pop
);

  logic [2:0]       step;
  logic             res_valid;
  logic             load;
  logic             is_byte;
  logic             final_step;
  logic [7:0]       word_byte;
  ucb_pkg::result_t next_result;

  assign is_byte    = head.echo && !step[2];
  assign final_step = is_byte ? (!head.has_tail && (step[1:0] == 2'd3)) : 1'b1;
  assign load       = !job_empty && (!res_valid || pop);
  assign job_pop    = load && final_step;
  assign empty      = !res_valid;

  always_comb begin
    case (step[1:0])
      2'd0:    word_byte = head.word[31:24];
      2'd1:    word_byte = head.word[23:16];
      2'd2:    word_byte = head.word[15:8];
      default: word_byte = head.word[7:0];
    endcase
  end

  always_comb begin
    if (is_byte) begin
      next_result         = '0;
      next_result.kind    = ucb_pkg::KIND_SEND_BYTE;
      next_result.tx_byte = word_byte;
    end else begin
      next_result = head.tail;
    end
    next_result.last = final_step;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= next_result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      step      <= '0;
    end else if (load) begin
      res_valid <= 1'b1;
      step      <= final_step ? 3'd0 : step + 3'd1;
    end else if (pop) begin
      res_valid <= 1'b0;
    end
  end

  // A finished job leaves a closing result behind
  a_pop_marks_last: assert property (@(posedge clk) disable iff (rst)
    job_pop |=> (res_valid && result.last))
    else $error("job retired without a last result");

  // Word bytes never run past the fourth
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (step[2] |-> (head.echo && head.has_tail && !job_empty)))
    else $error("sequencer step beyond the word");

  // Step returns to zero whenever a job is retired
  a_step_clear: assert property (@(posedge clk) disable iff (rst)
    job_pop |=> (step == 3'd0))
    else $error("step not cleared after job");

endmodule

FILE: hdl/uart_command_bridge_unit.sv
// ----------------------------------------------------------------------------
// uart_command_bridge_unit
// Serial command bridge: decodes command bytes, bus read returns and kernel
// completion into byte sends, instruction/memory writes and read requests.
// ----------------------------------------------------------------------------
//
//  channel   signals                      request moved
//  --------  ---------------------------  ------------------------------------
//  command   push, full, command          cmd, rx_byte, read_data
//  result    empty, pop, result           kind, tx_byte, instr_index,
//                                         bus_address, bus_data, last
//  config    cfg_valid, cfg_ready,        memory_base (loads memory pointer)
//            cfg_data
//
//  A command is taken every cycle while the job queue has room; the decoder
//  settles it in the cycle it is accepted.
//  The sequencer sends one result per cycle while results are popped; a command
//  gives up to five results (five for a loaded word: four echo bytes and
//  the write); that sequencer sets the sustained rate.
//  full rises only when the job queue is full; a stalled result side backs
//  up through the queue, never dropping a request.
//  Synchronous reset clears mode, counters, memory pointer and both queues.
//  cfg_ready is always high; writes belong in idle periods.
// ----------------------------------------------------------------------------
module uart_command_bridge_unit #(
  parameter int INSTR_INDEX_BITS = ucb_pkg::INSTR_INDEX_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  // command side
  input  logic              push,
  output logic              full,
  input  ucb_pkg::command_t command,
  // result side
  output logic              empty,
  input  logic              pop,
  output ucb_pkg::result_t  result,
  // configuration
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [31:0]       cfg_data
);

  logic          accept;
  logic          job_push;
  logic          job_full;
  logic          job_pop;
  logic          job_empty;
  ucb_pkg::job_t job;
  ucb_pkg::job_t head;

  assign cfg_ready = 1'b1;
  assign full      = job_full;
  // a command that makes no job still needs a free slot to be taken
  assign accept    = push && !job_full;

  ucb_front #(
    .INSTR_INDEX_BITS(INSTR_INDEX_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .command   (command),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .job_push  (job_push),
    .job       (job)
  );

  ucb_job_fifo u_jobs (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_job (job),
    .full     (job_full),
    .pop      (job_pop),
    .head     (head),
    .empty    (job_empty)
  );

  ucb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .result    (result),
    .empty     (empty),
    .pop       (pop)
  );

  // Queue is never written past its depth
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(job_push && job_full))
    else $error("job queue overflow");

  // Queue is never read while empty
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    job_pop |-> !job_empty)
    else $error("job queue underflow");

  // Reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty)
    else $error("result present after reset");

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the serial command bridge: drives command requests
// through the push/full side, predicts every result in a cycle-free model of
// the decoder and compares each popped result field by field, in order.
// ----------------------------------------------------------------------------
module tb;

  localparam int CLK_PERIOD    = 20;
  localparam int RANDOM_ITEMS  = 200;
  localparam int SETTLE_CYCLES = 10;   // decoder and queue flush after last result
  localparam int HOLD_OFF_LEN  = 400;  // long result-side stall in the pressure test
  localparam int MAX_REPORTS   = 40;

  // the one input code the bridge has no meaning for
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_LOAD_INSTR,
    MODE_LOAD_MEM,
    MODE_READ_ADDR,
    MODE_RUNNING
  } bridge_mode_t;

  // --------------------------------------------------------------------------
  // DUT hookup; every input starts at a known value
  // --------------------------------------------------------------------------
  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              push      = 1'b0;
  logic              full;
  ucb_pkg::command_t command   = '0;
  logic              empty;
  logic              pop       = 1'b0;
  ucb_pkg::result_t  result;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [31:0]       cfg_data  = '0;

  uart_command_bridge_unit dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .command   (command),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Traffic knobs and run statistics
  // --------------------------------------------------------------------------
  int unsigned send_idle_pct    = 0;   // chance per cycle the sender holds back
  int unsigned recv_idle_pct    = 0;   // chance per cycle pop stays low
  int unsigned hold_off_request = 0;   // set by a test, taken by the pop process
  int unsigned hold_left        = 0;
  int unsigned errors           = 0;
  int unsigned requests_sent    = 0;
  int unsigned results_checked  = 0;
  int unsigned full_stalls      = 0;
  int unsigned base_writes      = 0;

  // results predicted but not yet popped, oldest first
  ucb_pkg::result_t pending_results[$];

  // --------------------------------------------------------------------------
  // Bridge state as the predictor sees it
  // --------------------------------------------------------------------------
  bridge_mode_t                                 bridge_mode   = MODE_IDLE;
  logic [1:0]                                   payload_count = '0;
  logic [23:0]                                  payload_bytes = '0;
  logic [ucb_pkg::INSTR_INDEX_BITS_DEFAULT-1:0] instr_slot    = '0;
  logic [31:0]                                  memory_base   = '0;
  logic [31:0]                                  memory_ptr    = '0;
  logic                                         read_waiting  = 1'b0;

  function automatic void queue_result(input logic [2:0] kind, input logic [7:0] tx,
                                       input logic [15:0] index,
                                       input logic [31:0] address,
                                       input logic [31:0] data);
    ucb_pkg::result_t r;
    r.kind        = kind;
    r.tx_byte     = tx;
    r.instr_index = index;
    r.bus_address = address;
    r.bus_data    = data;
    r.last        = 1'b0;
    pending_results.push_back(r);
  endfunction

  // a word goes out on the serial side most significant byte first
  function automatic void queue_word_bytes(input logic [31:0] word);
    for (int i = 3; i >= 0; i--)
      queue_result(ucb_pkg::KIND_SEND_BYTE, word[8*i +: 8], '0, '0, '0);
  endfunction

  function automatic void decode_serial_byte(input logic [7:0] b);
    logic [31:0] word;
    if (bridge_mode == MODE_LOAD_INSTR || bridge_mode == MODE_LOAD_MEM ||
        bridge_mode == MODE_READ_ADDR) begin
      // collecting a payload word
      if (payload_count != 2'd3) begin
        payload_bytes = {payload_bytes[15:0], b};
        payload_count = payload_count + 2'd1;
        return;
      end
      word          = {payload_bytes, b};
      payload_count = '0;
      payload_bytes = '0;
      case (bridge_mode)
        MODE_LOAD_INSTR: begin
          queue_word_bytes(word);
          queue_result(ucb_pkg::KIND_INSTR_WR, '0, 16'(instr_slot), '0, word);
          instr_slot = instr_slot + 1'b1;
        end
        MODE_LOAD_MEM: begin
          queue_word_bytes(word);
          queue_result(ucb_pkg::KIND_MEM_WR, '0, '0, memory_ptr, word);
          memory_ptr = memory_ptr + ucb_pkg::WORD_STEP;
        end
        default: begin
          queue_result(ucb_pkg::KIND_MEM_RD, '0, '0, word, '0);
          read_waiting = 1'b1;
        end
      endcase
      bridge_mode = MODE_IDLE;
      return;
    end

    // idle or running: single-byte commands
    case (b)
      ucb_pkg::OP_LOAD_INSTR: begin
        bridge_mode   = MODE_LOAD_INSTR;
        payload_count = '0;
        payload_bytes = '0;
      end
      ucb_pkg::OP_RESET_INDEX: instr_slot = '0;
      ucb_pkg::OP_START: begin
        queue_result(ucb_pkg::KIND_START, '0, '0, '0, '0);
        bridge_mode = MODE_RUNNING;
      end
      ucb_pkg::OP_QUERY:
        queue_result(ucb_pkg::KIND_SEND_BYTE, {7'd0, bridge_mode == MODE_RUNNING},
                     '0, '0, '0);
      ucb_pkg::OP_READ_CYCLES: begin
        queue_result(ucb_pkg::KIND_CYCLES_RD, '0, '0, '0, '0);
        read_waiting = 1'b1;
      end
      ucb_pkg::OP_LOAD_MEM: begin
        bridge_mode   = MODE_LOAD_MEM;
        payload_count = '0;
        payload_bytes = '0;
      end
      ucb_pkg::OP_READ_MEM: begin
        bridge_mode   = MODE_READ_ADDR;
        payload_count = '0;
        payload_bytes = '0;
      end
      ucb_pkg::OP_WRITE_ZERO: begin
        queue_result(ucb_pkg::KIND_MEM_WR, '0, '0, memory_ptr, '0);
        memory_ptr = memory_ptr + ucb_pkg::WORD_STEP;
      end
      default: ;  // unknown command byte, dropped
    endcase
  endfunction

  // Works out every result one accepted request causes and flags the final one.
  function automatic void predict_request(input ucb_pkg::command_t c);
    int unsigned      size_at_start;
    ucb_pkg::result_t tail;
    size_at_start = pending_results.size();
    case (c.cmd)
      ucb_pkg::CMD_SERIAL_BYTE: decode_serial_byte(c.rx_byte);
      ucb_pkg::CMD_READ_DATA: begin
        if (read_waiting) begin
          read_waiting = 1'b0;
          queue_word_bytes(c.read_data);
        end
      end
      ucb_pkg::CMD_KERNEL_DONE: begin
        if (bridge_mode == MODE_RUNNING) begin
          bridge_mode = MODE_IDLE;
          queue_result(ucb_pkg::KIND_SEND_BYTE, ucb_pkg::DONE_BYTE, '0, '0, '0);
        end
      end
      default: ;
    endcase
    if (pending_results.size() > size_at_start) begin
      tail      = pending_results.pop_back();
      tail.last = 1'b1;
      pending_results.push_back(tail);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random pop, optional long hold-off, in-order compare.
  // Everything is sampled at the rising edge, before the edge's updates land.
  // --------------------------------------------------------------------------
  function automatic void report_error(input string field, input logic [31:0] want,
                                       input logic [31:0] got);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
               $time, field, want, got);
  endfunction

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) report_error(field, want, got);
  endfunction

  function automatic void check_result(input ucb_pkg::result_t got);
    ucb_pkg::result_t want;
    if (pending_results.size() == 0) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t ns: unexpected result, expected none, actual 0x%0h", $time, got);
      return;
    end
    want = pending_results.pop_front();
    results_checked++;
    check_field("kind",        32'(want.kind),        32'(got.kind));
    check_field("tx_byte",     32'(want.tx_byte),     32'(got.tx_byte));
    check_field("instr_index", 32'(want.instr_index), 32'(got.instr_index));
    check_field("bus_address", want.bus_address,      got.bus_address);
    check_field("bus_data",    want.bus_data,         got.bus_data);
    check_field("last",        32'(want.last),        32'(got.last));
  endfunction

  always @(posedge clk) begin : result_side
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_result(result);
      if (hold_off_request != 0) begin
        hold_left        = hold_off_request;
        hold_off_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Command side
  // --------------------------------------------------------------------------
  // Offers one request, after a random gap, and predicts it once it is taken.
  // push stays high into the next request when no gap is drawn.
  task automatic send_request(input logic [1:0] code, input logic [7:0] b,
                              input logic [31:0] data);
    ucb_pkg::command_t c;
    c.cmd       = code;
    c.rx_byte   = b;
    c.read_data = data;
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    push    <= 1'b1;
    command <= c;
    forever begin
      @(posedge clk);
      if (!full) break;
      full_stalls++;
    end
    predict_request(c);
    requests_sent++;
  endtask

  // unused fields carry random junk so that the bridge must ignore them
  task automatic send_byte(input logic [7:0] b);
    send_request(ucb_pkg::CMD_SERIAL_BYTE, b, $urandom());
  endtask

  task automatic send_read_data(input logic [31:0] data);
    send_request(ucb_pkg::CMD_READ_DATA, 8'($urandom_range(255)), data);
  endtask

  task automatic send_kernel_done();
    send_request(ucb_pkg::CMD_KERNEL_DONE, 8'($urandom_range(255)), $urandom());
  endtask

  task automatic send_word(input logic [31:0] word);
    for (int i = 3; i >= 0; i--) send_byte(word[8*i +: 8]);
  endtask

  // Lets the result side catch up, then gives the decoder time to go idle.
  task automatic wait_for_drain();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Memory base writes happen only with the bridge idle; they reload the
  // memory pointer as well.
  task automatic write_memory_base(input logic [31:0] base);
    wait_for_drain();
    cfg_valid <= 1'b1;
    cfg_data  <= base;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    memory_base  = base;
    memory_ptr   = base;
    base_writes++;
  endtask

  // One well-formed command sequence with random content, or now and then a
  // broken sequence or a stray request.
  task automatic send_random_sequence();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 18) begin
      send_byte(ucb_pkg::OP_LOAD_INSTR);
      send_word($urandom());
    end else if (pick < 34) begin
      send_byte(ucb_pkg::OP_LOAD_MEM);
      send_word($urandom());
    end else if (pick < 46) begin
      send_byte(ucb_pkg::OP_READ_MEM);
      send_word($urandom());
      if ($urandom_range(3) != 0) send_read_data($urandom());
    end else if (pick < 54) begin
      send_byte(ucb_pkg::OP_READ_CYCLES);
      if ($urandom_range(3) != 0) send_read_data($urandom());
    end else if (pick < 66) begin
      // kernel run, sometimes restarted or cut short by a read command
      send_byte(ucb_pkg::OP_START);
      repeat ($urandom_range(2)) send_byte(ucb_pkg::OP_QUERY);
      if ($urandom_range(4) == 0) send_byte(ucb_pkg::OP_START);
      if ($urandom_range(5) == 0) begin
        send_byte(ucb_pkg::OP_READ_MEM);
        send_word($urandom());
      end
      send_kernel_done();
    end else if (pick < 72) begin
      send_byte(ucb_pkg::OP_QUERY);
    end else if (pick < 79) begin
      send_byte(ucb_pkg::OP_WRITE_ZERO);
    end else if (pick < 82) begin
      send_byte(ucb_pkg::OP_RESET_INDEX);
    end else if (pick < 88) begin
      // payload interrupted by other traffic; the stray bytes may not finish the word
      case ($urandom_range(2))
        0:       send_byte(ucb_pkg::OP_LOAD_INSTR);
        1:       send_byte(ucb_pkg::OP_LOAD_MEM);
        default: send_byte(ucb_pkg::OP_READ_MEM);
      endcase
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)));
      send_request(2'($urandom_range(3)), 8'($urandom_range(255)), $urandom());
    end else begin
      send_request(2'($urandom_range(3)), 8'($urandom_range(255)), $urandom());
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Every command, the ignored inputs and the odd cases, no idling.
  task automatic test_directed();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_memory_base(32'h0000_0000);
    send_byte(8'h00);                     // unknown command bytes
    send_byte(8'hFF);
    send_byte(ucb_pkg::OP_QUERY);         // answers 0 when not running
    send_request(CMD_UNUSED, 8'hA5, 32'hFFFF_FFFF);
    send_kernel_done();                   // kernel done while idle is dropped
    send_read_data(32'hFFFF_FFFF);        // read data nobody asked for
    send_byte(ucb_pkg::OP_START);
    send_byte(ucb_pkg::OP_QUERY);         // answers 1 while running
    send_byte(ucb_pkg::OP_START);         // start again while running
    send_kernel_done();
    send_kernel_done();
    send_byte(ucb_pkg::OP_LOAD_INSTR);
    send_word(32'hFF00_A55A);
    send_byte(ucb_pkg::OP_RESET_INDEX);
    send_byte(ucb_pkg::OP_LOAD_MEM);
    send_word(32'h807F_01FE);
    send_byte(ucb_pkg::OP_WRITE_ZERO);
    send_byte(ucb_pkg::OP_READ_MEM);
    send_word(32'hFFFF_FFFC);
    send_byte(ucb_pkg::OP_READ_CYCLES);   // second request while one is pending
    send_read_data(32'hFFFF_FFFF);
  endtask

  task automatic test_random_phase(input int unsigned send_pct, input int unsigned recv_pct,
                                   input logic [31:0] base, input int unsigned count);
    int unsigned target;
    write_memory_base(base);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    target        = requests_sent + count;
    while (requests_sent < target) send_random_sequence();
  endtask

  // Result side holds off while loads keep coming, so the job queue fills
  // and full has to hold the command side back.
  task automatic test_backpressure();
    wait_for_drain();
    send_idle_pct    = 0;
    recv_idle_pct    = 0;
    hold_off_request = HOLD_OFF_LEN;
    repeat (6) begin
      send_byte(ucb_pkg::OP_LOAD_MEM);
      send_word($urandom());
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    // pointer near the top so that memory writes wrap past zero
    test_random_phase(8, 80, 32'hFFFF_FFF0, RANDOM_ITEMS / 3);
    test_random_phase(80, 8, 32'hFFFF_FFFF, RANDOM_ITEMS / 3);
    test_backpressure();
    test_random_phase(0, 0, $urandom(), RANDOM_ITEMS / 3);
    wait_for_drain();

    $display("Sent %0d command requests and checked %0d results across %0d memory base",
             requests_sent, results_checked, base_writes);
    $display("settings; the command side was held off by full for %0d cycles.",
             full_stalls);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #(20_000_000);
    $display("Timeout with %0d results still outstanding", pending_results.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/ucb_pkg.sv
hdl/ucb_front.sv
hdl/ucb_job_fifo.sv
hdl/ucb_back.sv
hdl/uart_command_bridge_unit.sv
sim/tb.sv
